/* src/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mdsp_pkg.sv */
// ----------------------------------------------------------------------------
// mdsp_pkg
// Shared widths, constants and the control struct for the digit picker.
// ----------------------------------------------------------------------------
package mdsp_pkg;

  localparam int DIGIT_W      = 4;
  localparam int LEN_W        = 16;
  localparam int VALUE_W      = 40;
  localparam int TOTAL_W      = 64;
  localparam int CFG_W        = 4;
  // effective keep count, wide enough for any stack size up to 31
  localparam int KEEP_W       = 5;
  localparam int MAX_KEEP_DEF = 12;
  localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(12);

  // per-digit control broadcast to every stage of the stack
  typedef struct packed {
    logic               step;
    logic               first;
    logic               last;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   remaining;
    logic [KEEP_W-1:0]  keep;
  } ctl_t;

endpackage

/* src/mdsp_if.sv */
// ----------------------------------------------------------------------------
// mdsp_digit_if / mdsp_result_if
// Valid/ready channels for digit words and result words.
// ----------------------------------------------------------------------------
interface mdsp_digit_if;
  logic                          valid;
  logic                          ready;
  logic [mdsp_pkg::DIGIT_W-1:0]  digit;
  logic                          first_of_line;
  logic                          last_of_line;
  logic [mdsp_pkg::LEN_W-1:0]    line_length;

  modport source (output valid, digit, first_of_line, last_of_line, line_length,
                  input ready);
  modport sink   (input valid, digit, first_of_line, last_of_line, line_length,
                  output ready);
endinterface

interface mdsp_result_if;
  logic                          valid;
  logic                          ready;
  logic [mdsp_pkg::VALUE_W-1:0]  line_value;
  logic [mdsp_pkg::TOTAL_W-1:0]  running_total;

  modport source (output valid, line_value, running_total, input ready);
  modport sink   (input valid, line_value, running_total, output ready);
endinterface

/* src/mdsp_stage.sv */
// ----------------------------------------------------------------------------
// mdsp_stage
// One slot of the digit stack: holds a digit, its valid bit and the value
// of the stack prefix ending here; decides pop and push with its neighbors.
// ----------------------------------------------------------------------------
module mdsp_stage #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mdsp_pkg::ctl_t               ctl,
  input  logic                         below_keep,
  input  logic [mdsp_pkg::VALUE_W-1:0] below_prefix,
  input  logic                         above_clear,
  output logic                         keep_up,
  output logic                         clear_down,
  output logic [mdsp_pkg::VALUE_W-1:0] prefix,
  output logic                         valid_step,
  output logic [mdsp_pkg::VALUE_W-1:0] prefix_step
);
  import mdsp_pkg::*;

  logic               valid;
  logic [DIGIT_W-1:0] digit;
  logic               valid_cur;
  logic               pop_ok;
  logic               cleared;
  logic               write;
  logic [LEN_W:0]     reach;

  // digits that stay below this slot plus digits still to come
  assign reach     = (LEN_W+1)'(IDX) + {1'b0, ctl.remaining};
  assign valid_cur = valid && !ctl.first;
  assign pop_ok    = valid_cur && (digit < ctl.digit) && (reach >= (LEN_W+1)'(ctl.keep));
  // empty or popped; pops only run down from the top
  assign cleared   = !valid_cur || (pop_ok && above_clear);
  assign keep_up   = valid_cur && !cleared;
  assign clear_down = cleared;
  // new digit lands on the first free slot above the kept part
  assign write     = cleared && below_keep && (KEEP_W'(IDX) < ctl.keep);

  assign valid_step  = keep_up || write;
  assign prefix_step = write ? ((below_prefix << 3) + (below_prefix << 1)
                                + VALUE_W'(ctl.digit))
                             : prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.step) begin
      valid <= valid_step && !ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && write) begin
      digit  <= ctl.digit;
      prefix <= prefix_step;
    end
  end

endmodule

/* src/max_digit_subsequence_picker_core.sv */
// ----------------------------------------------------------------------------
// max_digit_subsequence_picker_core
// Largest keep_count-digit subsequence (keep_count capped at MAX_KEEP) of
// each line, built on a row of stack slots, with a running total of the
// line values.
// throughput: one digit word per cycle unless a held result is not taken,
//   set by the combinational pop/push decision across the row of stack slots
// result: the result word is valid in the cycle after the last digit is taken
// a held result stalls digits only when the result word is not taken
// reset: synchronous; empties the stack, zeroes the total, keep_count to 12
module max_digit_subsequence_picker_core #(
  parameter int MAX_KEEP = mdsp_pkg::MAX_KEEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mdsp_pkg::CFG_W-1:0] cfg_wdata,
  mdsp_digit_if.sink                 digits,
  mdsp_result_if.source              results
);
  import mdsp_pkg::*;

  logic [CFG_W-1:0]   keep_count;
  logic [LEN_W-1:0]   remaining;
  logic [LEN_W-1:0]   remaining_cur;
  logic [KEEP_W-1:0]  keep_eff;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [VALUE_W-1:0] value_next;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               accept;
  ctl_t               ctl;

  logic [MAX_KEEP:0]  keep_chain;
  logic [MAX_KEEP:0]  clear_chain;
  logic [VALUE_W-1:0] prefix_chain [0:MAX_KEEP];
  logic [MAX_KEEP:0]  valid_step;
  logic [VALUE_W-1:0] prefix_step [0:MAX_KEEP-1];

  assign digits.ready = !out_valid || results.ready;
  assign accept       = digits.valid && digits.ready;

  assign keep_eff = (KEEP_W'(keep_count) > KEEP_W'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP)
                                                             : KEEP_W'(keep_count);
  assign remaining_cur = digits.first_of_line ? digits.line_length : remaining;

  assign ctl.step      = accept;
  assign ctl.first     = digits.first_of_line;
  assign ctl.last      = digits.last_of_line;
  assign ctl.digit     = digits.digit;
  assign ctl.remaining = remaining_cur;
  assign ctl.keep      = keep_eff;

  assign keep_chain[0]         = 1'b1;
  assign prefix_chain[0]       = '0;
  assign clear_chain[MAX_KEEP] = 1'b1;
  assign valid_step[MAX_KEEP]  = 1'b0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_slot
    mdsp_stage #(.IDX(i)) u_stage (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .below_keep   (keep_chain[i]),
      .below_prefix (prefix_chain[i]),
      .above_clear  (clear_chain[i+1]),
      .keep_up      (keep_chain[i+1]),
      .clear_down   (clear_chain[i]),
      .prefix       (prefix_chain[i+1]),
      .valid_step   (valid_step[i]),
      .prefix_step  (prefix_step[i])
    );
  end

  // line value is the prefix held by the new top of stack
  always_comb begin
    value_next = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (valid_step[i] && !valid_step[i+1]) begin
        value_next = value_next | prefix_step[i];
      end
    end
  end

  assign total_next = total + TOTAL_W'(value_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (digits.last_of_line) begin
          remaining <= '0;
          total     <= total_next;
        end else begin
          remaining <= (remaining_cur != '0) ? remaining_cur - LEN_W'(1) : '0;
        end
      end
      if (accept && digits.last_of_line) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && digits.last_of_line) begin
      out_value <= value_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.line_value    = out_value;
  assign results.running_total = total;

endmodule

/* src/mdsp_checker.sv */
// ----------------------------------------------------------------------------
// mdsp_checker
// Port-level checks on the digit picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mdsp_pkg::TOTAL_W-1:0] out_total
);
  import mdsp_pkg::*;

  // a line end always produces a result word on the next cycle
  `CHK_ASSERT(a_last_gives_result, clk, rst, in_valid && in_ready && in_last |=> out_valid, "no result after last digit")

  // no result word appears without a line end
  `CHK_ASSERT(a_no_spurious_result, clk, rst, !out_valid && !(in_valid && in_ready && in_last) |=> !out_valid, "result without last digit")

  // an empty result slot never blocks digits
  `CHK_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "digits stalled with no result pending")

  // stalled result word stays valid and its running total holds
  `CHK_ASSERT(a_result_held, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_total), "stalled result dropped or changed")

endmodule

bind max_digit_subsequence_picker_core mdsp_checker u_mdsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (digits.valid),
  .in_ready  (digits.ready),
  .in_last   (digits.last_of_line),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_total (results.running_total)
);

/* test/tb_max_digit_subsequence_picker_core.sv */
// ----------------------------------------------------------------------------
// tb_max_digit_subsequence_picker_core
// Streams digit words through the picker and checks each line result
// against a stack predictor. A short directed table comes first, then
// random phases under several keep_count settings. Sender bursts, receiver
// stalls and one long receiver hold-off keep both handshakes busy.
// ----------------------------------------------------------------------------
module tb_max_digit_subsequence_picker_core;

  import mdsp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 120;
  localparam int NUM_PHASES    = 10;
  localparam int DIR_ROWS      = 25;

  typedef enum logic [0:0] {ROW_DIGIT, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RCV_OPEN, RCV_RANDOM, RCV_SPARSE} rcv_mode_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               first;
    logic               last;
    logic [LEN_W-1:0]   len;
    logic               lit;
    logic [VALUE_W-1:0] lit_value;
    logic [TOTAL_W-1:0] lit_total;
  } digit_word_t;

  typedef struct packed {
    row_kind_t   kind;
    digit_word_t w;
  } dir_row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] line_value;
    logic [TOTAL_W-1:0] running_total;
  } line_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  mdsp_digit_if  dig_if ();
  mdsp_result_if res_if ();

  max_digit_subsequence_picker_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .digits    (dig_if),
    .results   (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed table; digit holds the keep value on config rows
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_DIGIT, '{4'd9,  1'b1, 1'b1, 16'd1,     1'b1, 40'd9,   64'd9}},
    '{ROW_DIGIT, '{4'd0,  1'b1, 1'b1, 16'd1,     1'b1, 40'd0,   64'd9}},
    '{ROW_DIGIT, '{4'd1,  1'b1, 1'b0, 16'd3,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd2,  1'b0, 1'b0, 16'd3,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd3,  1'b0, 1'b1, 16'd3,     1'b1, 40'd123, 64'd132}},
    '{ROW_CFG,   '{4'd2,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd8,  1'b1, 1'b0, 16'd3,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd1,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd9,  1'b0, 1'b1, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_CFG,   '{4'd0,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd7,  1'b1, 1'b1, 16'd1,     1'b0, 40'd0,   64'd0}},
    '{ROW_CFG,   '{4'd15, 1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd15, 1'b1, 1'b0, 16'd2,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd15, 1'b0, 1'b1, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd5,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd6,  1'b0, 1'b1, 16'hffff,  1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd1,  1'b1, 1'b0, 16'd1,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd2,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd3,  1'b0, 1'b1, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd3,  1'b1, 1'b0, 16'hffff,  1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd4,  1'b0, 1'b1, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_CFG,   '{4'd1,  1'b0, 1'b0, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd0,  1'b1, 1'b0, 16'd2,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd9,  1'b0, 1'b1, 16'd0,     1'b0, 40'd0,   64'd0}},
    '{ROW_DIGIT, '{4'd10, 1'b1, 1'b1, 16'd1,     1'b0, 40'd0,   64'd0}}
  };

  // picker state as the testbench sees it
  logic [CFG_W-1:0]   keep_cfg;
  logic [DIGIT_W-1:0] pick_stack [MAX_KEEP_DEF];
  int                 pick_depth;
  int                 pick_left;
  logic [TOTAL_W-1:0] pick_total;

  digit_word_t  stim_q [$];
  line_result_t expected_q [$];
  digit_word_t  cur_word;
  bit           offering;
  int           burst_left;
  int           gap_left;

  bit        hold_req;
  int        hold_left;
  int        holds_done;
  rcv_mode_t rcv_mode;
  int        rcv_cycle;

  int error_count;
  int words_in;
  int results_checked;
  int keep_writes;
  int cycle_count;

  task automatic reset_picker();
    keep_cfg   = KEEP_RESET;
    pick_depth = 0;
    pick_left  = 0;
    pick_total = '0;
    foreach (pick_stack[i]) pick_stack[i] = '0;
  endtask

  // advance the predicted stack by one digit word, queue a line result on last
  task automatic take_digit(input digit_word_t w);
    int           k;
    int           r;
    logic [63:0]  acc;
    line_result_t res;
    k = (keep_cfg > MAX_KEEP_DEF) ? MAX_KEEP_DEF : int'(keep_cfg);
    if (w.first) begin
      pick_depth = 0;
      pick_left  = int'(w.len);
    end
    r = pick_left;
    // pop smaller tops while the rest of the line can still refill the stack
    while (pick_depth > 0 && pick_stack[pick_depth-1] < w.digit &&
           (pick_depth - 1) + r >= k)
      pick_depth--;
    if (pick_depth < k) begin
      pick_stack[pick_depth] = w.digit;
      pick_depth++;
    end
    pick_left = (r > 0) ? r - 1 : 0;
    if (w.last) begin
      acc = '0;
      for (int i = 0; i < pick_depth; i++) acc = acc * 64'd10 + 64'(pick_stack[i]);
      res.line_value    = acc[VALUE_W-1:0];
      pick_total        = pick_total + 64'(res.line_value);
      res.running_total = pick_total;
      if (w.lit) begin
        res.line_value    = w.lit_value;
        res.running_total = w.lit_total;
      end
      expected_q = {expected_q, res};
      pick_depth = 0;
      pick_left  = 0;
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      dig_if.valid         <= 1'b0;
      dig_if.digit         <= '0;
      dig_if.first_of_line <= 1'b0;
      dig_if.last_of_line  <= 1'b0;
      dig_if.line_length   <= '0;
      offering   = 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      nxt_valid = dig_if.valid;
      if (dig_if.valid && dig_if.ready) begin
        take_digit(cur_word);
        words_in++;
        offering  = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          cur_word  = stim_q.pop_front();
          offering  = 1'b1;
          nxt_valid = 1'b1;
          dig_if.digit         <= cur_word.digit;
          dig_if.first_of_line <= cur_word.first;
          dig_if.last_of_line  <= cur_word.last;
          dig_if.line_length   <= cur_word.len;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      dig_if.valid <= nxt_valid;
    end
  end

  // receiver: checks each result word, stalls on its own pattern
  always @(posedge clk) begin
    line_result_t exp_res;
    logic         nxt_ready;
    if (rst) begin
      res_if.ready <= 1'b0;
      rcv_mode  = RCV_OPEN;
      rcv_cycle = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: line_value %0d running_total %0d",
                 res_if.line_value, res_if.running_total);
          error_count++;
        end else begin
          exp_res = expected_q.pop_front();
          results_checked++;
          if (res_if.line_value !== exp_res.line_value) begin
            $error("line_value: expected %0d, actual %0d",
                   exp_res.line_value, res_if.line_value);
            error_count++;
          end
          if (res_if.running_total !== exp_res.running_total) begin
            $error("running_total: expected %0d, actual %0d",
                   exp_res.running_total, res_if.running_total);
            error_count++;
          end
        end
      end
      rcv_cycle++;
      if (rcv_cycle % 50 == 0) rcv_mode = rcv_mode_t'($urandom_range(0, 2));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        case (rcv_mode)
          RCV_OPEN:   nxt_ready = 1'b1;
          RCV_RANDOM: nxt_ready = 1'($urandom_range(0, 1));
          default:    nxt_ready = (rcv_cycle % 5 == 0);
        endcase
      end
      res_if.ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_max_digit_subsequence_picker_core failed");
      $finish;
    end
  end

  // wait until every word is in and every result out, then let the block settle
  task automatic wait_drained();
    while (stim_q.size() != 0 || offering || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    keep_cfg = value;
    keep_writes++;
  endtask

  // one line of random digits, mostly well formed
  task automatic queue_line(input int k, inout int queued);
    int          n;
    int          shape;
    bit          well;
    int          fault;
    int          d_hi;
    int          d_lo;
    digit_word_t w;
    shape = $urandom_range(0, 99);
    if (shape < 20) n = $urandom_range(1, (k > 2) ? k - 1 : 1);
    else if (shape < 95) n = $urandom_range(1, 24);
    else n = $urandom_range(30, 60);
    well  = ($urandom_range(0, 99) < 85);
    fault = $urandom_range(0, 3);
    d_hi  = ($urandom_range(0, 4) == 0) ? 15 : 9;
    d_lo  = ($urandom_range(0, 7) == 0) ? 9 : 0;
    for (int i = 0; i < n; i++) begin
      w       = '0;
      w.digit = DIGIT_W'($urandom_range(d_lo, d_hi));
      w.first = (i == 0);
      w.last  = (i == n - 1);
      w.len   = (i == 0) ? LEN_W'(n) : LEN_W'($urandom_range(0, 65535));
      if (!well) begin
        case (fault)
          0: if (i == 0) w.len = LEN_W'($urandom_range(0, 65535));
          1: w.first = 1'b0;
          2: w.last = 1'b0;
          default: begin
            w.first = 1'($urandom_range(0, 1));
            w.last  = ($urandom_range(0, 7) == 0);
          end
        endcase
      end
      stim_q = {stim_q, w};
      queued++;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_keep [NUM_PHASES];
    int               queued;
    int               k;
    phase_keep = '{4'd12, 4'd1, 4'd2, 4'd13, 4'd0, 4'd7, 4'd15, 4'd5, 4'd12, 4'd3};
    phase_keep[NUM_PHASES-1] = CFG_W'($urandom_range(0, 15));
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    hold_req             = 1'b0;
    reset_picker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_drained();
        write_keep(dir_table[i].w.digit);
      end else begin
        stim_q = {stim_q, dir_table[i].w};
      end
    end
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_keep(phase_keep[p]);
      k = (phase_keep[p] > MAX_KEEP_DEF) ? MAX_KEEP_DEF : int'(phase_keep[p]);
      queued = 0;
      while (queued < PHASE_WORDS) queue_line(k, queued);
      // stall the result side long enough for the digit side to back up
      if (p == 2) hold_req = 1'b1;
      wait_drained();
    end

    if (expected_q.size() != 0) begin
      $error("%0d line results never arrived", expected_q.size());
      error_count++;
    end
    $display("covered %0d digit words and %0d line results over %0d keep settings",
             words_in, results_checked, keep_writes);
    $display("short, over-long and unmarked lines, digits above nine, %0d long hold-off(s)",
             holds_done);
    if (error_count == 0) begin
      $display("tb_max_digit_subsequence_picker_core passed");
    end else begin
      $display("tb_max_digit_subsequence_picker_core failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/mdsp_pkg.sv
src/mdsp_if.sv
src/mdsp_stage.sv
src/max_digit_subsequence_picker_core.sv
src/mdsp_checker.sv
test/tb_max_digit_subsequence_picker_core.sv
